FILE: hdl/psc_pkg.sv
// psc_pkg: shared types, constants and line tables for the PAL sync and color-bar generator.
// Used by psc_cfg_regs, psc_timing, psc_levels and pal_sync_colorbar_generator.
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    localparam int LINE_W  = 10;
    localparam int PIX_W   = 11;
    localparam int BIDX_W  = 4;
    localparam int BTICK_W = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 11;
    localparam int OUT_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_LINE_PERIOD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_LINE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_EQ_WIDTH    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BROAD_WIDTH = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BAR_START   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_BAR_WIDTH   = 3'd6;

    localparam logic [10:0] RST_LINE_PERIOD = 11'd1135;
    localparam logic [9:0]  RST_HALF_LINE   = 10'd567;
    localparam logic [7:0]  RST_SYNC_WIDTH  = 8'd83;
    localparam logic [7:0]  RST_EQ_WIDTH    = 8'd42;
    localparam logic [9:0]  RST_BROAD_WIDTH = 10'd530;
    localparam logic [10:0] RST_BAR_START   = 11'd185;
    localparam logic [7:0]  RST_BAR_WIDTH   = 8'd116;

    localparam logic [LINE_W-1:0] RST_LINE_COUNT = 10'd5;
    localparam logic [BIDX_W-1:0] BAR_FIRST = 4'd1;
    localparam logic [BIDX_W-1:0] BAR_LAST  = 4'd8;
    localparam logic [BIDX_W-1:0] BAR_DONE  = 4'd9;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_SYNC,
        KIND_EQ,
        KIND_BROAD,
        KIND_IMAGE
    } kind_t;

    typedef struct packed {
        logic [10:0] line_period;
        logic [9:0]  half_line;
        logic [7:0]  sync_width;
        logic [7:0]  eq_width;
        logic [9:0]  broad_width;
        logic [10:0] bar_start;
        logic [7:0]  bar_width;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_count;
        logic [LINE_W-1:0]  line_count;
        logic               vsync;
        logic               parity;
        logic [BIDX_W-1:0]  bar_index;
        logic [BTICK_W-1:0] bar_tick;
    } timing_t;

    // kind of the first half of the line following line l
    function automatic kind_t next_line_kind(input logic [LINE_W-1:0] l);
        kind_t k;
        if (l inside {[10'd0:10'd1]})          k = KIND_BROAD;
        else if (l inside {[10'd2:10'd3]})     k = KIND_EQ;
        else if (l inside {[10'd4:10'd21]})    k = KIND_SYNC;
        else if (l inside {[10'd22:10'd308]})  k = KIND_IMAGE;
        else if (l inside {[10'd309:10'd311]}) k = KIND_EQ;
        else if (l inside {[10'd312:10'd313]}) k = KIND_BROAD;
        else if (l inside {[10'd314:10'd316]}) k = KIND_EQ;
        else if (l inside {[10'd317:10'd333]}) k = KIND_SYNC;
        else if (l inside {[10'd334:10'd621]}) k = KIND_IMAGE;
        else if (l inside {[10'd622:10'd623]}) k = KIND_EQ;
        else                                   k = KIND_BROAD;
        return k;
    endfunction

    // kind of the second half of line l
    function automatic kind_t half_kind(input logic [LINE_W-1:0] l);
        kind_t k;
        if (l inside {[10'd0:10'd1]})          k = KIND_BROAD;
        else if (l inside {[10'd2:10'd4]})     k = KIND_EQ;
        else if (l inside {[10'd5:10'd309]})   k = KIND_NONE;
        else if (l inside {[10'd310:10'd311]}) k = KIND_EQ;
        else if (l inside {[10'd312:10'd314]}) k = KIND_BROAD;
        else if (l inside {[10'd315:10'd316]}) k = KIND_EQ;
        else if (l inside {[10'd317:10'd621]}) k = KIND_NONE;
        else                                   k = KIND_EQ;
        return k;
    endfunction

    // kind of the first half of line l; last_line is the frame's final line
    function automatic kind_t first_kind(input logic [LINE_W-1:0] l,
                                         input logic [LINE_W-1:0] last_line);
        logic [LINE_W-1:0] prev;
        prev = (l == '0) ? last_line : l - 10'd1;
        return next_line_kind(prev);
    endfunction

    // white, yellow, cyan, green, magenta, red, blue, black
    function automatic logic [2:0] bar_colour(input logic [2:0] idx);
        logic [2:0] c;
        case (idx)
            3'd0:    c = 3'h7;
            3'd1:    c = 3'h6;
            3'd2:    c = 3'h3;
            3'd3:    c = 3'h2;
            3'd4:    c = 3'h5;
            3'd5:    c = 3'h4;
            3'd6:    c = 3'h1;
            default: c = 3'h0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/psc_cfg_regs.sv
// psc_cfg_regs: configuration register file for the sync generator.
// Depends on psc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psc_cfg_regs
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [psc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [psc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output psc_pkg::cfg_t                          cfg
);

    psc_pkg::cfg_t cfg_reg;
    psc_pkg::cfg_t cfg_next;
    logic          wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (cfg_addr)
                psc_pkg::REG_LINE_PERIOD: cfg_next.line_period = cfg_data;
                psc_pkg::REG_HALF_LINE:   cfg_next.half_line   = cfg_data[9:0];
                psc_pkg::REG_SYNC_WIDTH:  cfg_next.sync_width  = cfg_data[7:0];
                psc_pkg::REG_EQ_WIDTH:    cfg_next.eq_width    = cfg_data[7:0];
                psc_pkg::REG_BROAD_WIDTH: cfg_next.broad_width = cfg_data[9:0];
                psc_pkg::REG_BAR_START:   cfg_next.bar_start   = cfg_data;
                psc_pkg::REG_BAR_WIDTH:   cfg_next.bar_width   = cfg_data[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_period <= psc_pkg::RST_LINE_PERIOD;
            cfg_reg.half_line   <= psc_pkg::RST_HALF_LINE;
            cfg_reg.sync_width  <= psc_pkg::RST_SYNC_WIDTH;
            cfg_reg.eq_width    <= psc_pkg::RST_EQ_WIDTH;
            cfg_reg.broad_width <= psc_pkg::RST_BROAD_WIDTH;
            cfg_reg.bar_start   <= psc_pkg::RST_BAR_START;
            cfg_reg.bar_width   <= psc_pkg::RST_BAR_WIDTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/psc_timing.sv
// psc_timing: pixel, line, field-flag and color-bar counters, advanced once per tick.
// Depends on psc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psc_timing
#(
    parameter int LINES_PER_FRAME = 625
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire psc_pkg::cfg_t  cfg,
    output psc_pkg::timing_t    st
);

    localparam logic [psc_pkg::LINE_W-1:0] LAST_LINE =
        psc_pkg::LINE_W'(LINES_PER_FRAME - 1);
    localparam logic [psc_pkg::LINE_W:0] LPF = (psc_pkg::LINE_W + 1)'(LINES_PER_FRAME);

    psc_pkg::timing_t st_reg;
    psc_pkg::timing_t st_next;

    logic [psc_pkg::PIX_W:0]     pix_inc;
    logic                        wrap;
    logic [psc_pkg::LINE_W:0]    line_inc;
    logic [psc_pkg::BIDX_W-1:0]  idx_base;
    logic [psc_pkg::BTICK_W-1:0] tick_base;
    logic [psc_pkg::BTICK_W-1:0] tick_inc;
    logic                        image_n;

    assign st = st_reg;

    always_comb
    begin
        st_next   = st_reg;
        pix_inc   = {1'b0, st_reg.pixel_count} + 12'd1;
        wrap      = pix_inc >= {1'b0, cfg.line_period};
        line_inc  = {1'b0, st_reg.line_count} + 11'd1;
        idx_base  = st_reg.bar_index;
        tick_base = st_reg.bar_tick;
        if (wrap)
        begin
            st_next.pixel_count = '0;
            if (st_reg.line_count inside {[10'd2:10'd3], 10'd314})
                st_next.vsync = 1'b1;
            if (st_reg.line_count == 10'd311)
            begin
                st_next.vsync  = 1'b0;
                st_next.parity = 1'b0;
            end
            if (st_reg.line_count >= 10'd624)
            begin
                st_next.vsync  = 1'b0;
                st_next.parity = 1'b1;
            end
            st_next.line_count = (line_inc >= LPF) ? '0 : line_inc[psc_pkg::LINE_W-1:0];
            idx_base  = '0;
            tick_base = '0;
        end
        else
        begin
            st_next.pixel_count = pix_inc[psc_pkg::PIX_W-1:0];
        end

        image_n  = psc_pkg::first_kind(st_next.line_count, LAST_LINE) == psc_pkg::KIND_IMAGE;
        tick_inc = tick_base + 8'd1;
        st_next.bar_index = idx_base;
        st_next.bar_tick  = tick_base;
        if (!image_n || st_next.pixel_count < cfg.bar_start)
        begin
            st_next.bar_index = '0;
            st_next.bar_tick  = '0;
        end
        else if (st_next.pixel_count == cfg.bar_start)
        begin
            st_next.bar_index = psc_pkg::BAR_FIRST;
            st_next.bar_tick  = '0;
        end
        else if (idx_base >= psc_pkg::BAR_FIRST && idx_base <= psc_pkg::BAR_LAST)
        begin
            if (tick_inc >= cfg.bar_width)
            begin
                st_next.bar_tick  = '0;
                st_next.bar_index = idx_base + 4'd1;
            end
            else
            begin
                st_next.bar_tick = tick_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.pixel_count <= '0;
            st_reg.line_count  <= psc_pkg::RST_LINE_COUNT;
            st_reg.vsync       <= 1'b1;
            st_reg.parity      <= 1'b1;
            st_reg.bar_index   <= '0;
            st_reg.bar_tick    <= '0;
        end
        else if (adv)
        begin
            st_reg <= st_next;
        end
    end

    a_bar_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.bar_index <= psc_pkg::BAR_DONE)
        else $error("bar index beyond the done code");

    a_line_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, st_reg.line_count} < LPF)
        else $error("line counter outside the frame");

    a_hold_without_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(st_reg))
        else $error("counters moved without a tick");

    a_wrap_moves_line: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && wrap) |=> (st_reg.pixel_count == '0
                           && st_reg.line_count != $past(st_reg.line_count)))
        else $error("line end did not advance the line counter");

endmodule

`default_nettype wire

FILE: hdl/psc_levels.sv
// psc_levels: sync level, flags and bar color for the current position, in a result register.
// Depends on psc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psc_levels
#(
    parameter int LINES_PER_FRAME = 625
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            load,
    input  wire psc_pkg::cfg_t                   cfg,
    input  wire psc_pkg::timing_t                st,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic [psc_pkg::OUT_DATA_W-1:0]       m_tdata
);

    localparam logic [psc_pkg::LINE_W-1:0] LAST_LINE =
        psc_pkg::LINE_W'(LINES_PER_FRAME - 1);

    psc_pkg::kind_t k_first;
    psc_pkg::kind_t k_half;
    psc_pkg::kind_t k_sel;
    logic [9:0]     pulse_w;
    logic [10:0]    pos;
    logic           low;
    logic           image;
    logic [2:0]     rgb;

    logic                            m_tvalid_reg;
    logic                            m_tvalid_next;
    logic [psc_pkg::OUT_DATA_W-1:0]  m_tdata_reg;
    logic [psc_pkg::OUT_DATA_W-1:0]  m_tdata_next;

    always_comb
    begin
        k_first = psc_pkg::first_kind(st.line_count, LAST_LINE);
        k_half  = psc_pkg::half_kind(st.line_count);
        image   = k_first == psc_pkg::KIND_IMAGE;
        if (st.pixel_count < {1'b0, cfg.half_line})
        begin
            k_sel = k_first;
            pos   = st.pixel_count;
        end
        else
        begin
            k_sel = k_half;
            pos   = st.pixel_count - {1'b0, cfg.half_line};
        end
        case (k_sel)
            psc_pkg::KIND_EQ:    pulse_w = {2'b00, cfg.eq_width};
            psc_pkg::KIND_BROAD: pulse_w = cfg.broad_width;
            psc_pkg::KIND_NONE:  pulse_w = '0;
            default:             pulse_w = {2'b00, cfg.sync_width};
        endcase
        low = pos < {1'b0, pulse_w};

        if (image && st.bar_index >= psc_pkg::BAR_FIRST && st.bar_index <= psc_pkg::BAR_LAST)
            rgb = psc_pkg::bar_colour(3'(st.bar_index - 4'd1));
        else
            rgb = 3'h0;
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'd0, image, st.line_count, rgb, st.parity, st.vsync, ~low};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> m_tvalid)
        else $error("loaded result not presented");

    a_rgb_needs_image: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !image) |=> m_tdata[5:3] == 3'h0 && m_tdata[16] == 1'b0)
        else $error("color on a non-image line");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> m_tdata[psc_pkg::OUT_DATA_W-1:17] == '0)
        else $error("padding bits set");

endmodule

`default_nettype wire

FILE: hdl/pal_sync_colorbar_generator.sv
// pal_sync_colorbar_generator: PAL 625-line composite sync and color-bar generator, top level.
// Depends on psc_pkg, psc_cfg_regs, psc_timing and psc_levels.
//
// Usage:
//   s_* carries one tick item per transfer; s_tdata[0] = 1 advances the
//   pixel/line counters by one clock, 0 holds them. Every accepted item
//   produces exactly one result on m_*, describing the position before
//   the advance. cfg_* writes one of seven timing registers (index in
//   cfg_addr, value in cfg_data); the user must write only while the
//   stream is idle, which the block itself leaves unenforced; cfg_ready is always high.
//   The result is registered and valid in the cycle after the input transfer.
//   Throughput: one item per cycle; the result register frees up in the
//   same cycle it is taken, so s_tready = !m_tvalid || m_tready.
//   Stall: if m_tready is low with a result held, s_tready drops and the
//   counters stop until the result is taken.
//   Reset: registers return to PAL defaults, line counter to 5, pixel 0,
//   both flags high, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module pal_sync_colorbar_generator
#(
    parameter int LINES_PER_FRAME = 625
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [0] tick
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] csync, [1] vsync_flag, [2] even_odd, [5:3] rgb, [15:6] line_number,
    // [16] image_line, [23:17] zero
    output logic [psc_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [psc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [psc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    psc_pkg::cfg_t    cfg;
    psc_pkg::timing_t st;
    logic             in_xfer;
    logic             adv;

    assign s_tready = ~m_tvalid | m_tready;
    assign in_xfer  = s_tvalid & s_tready;
    assign adv      = in_xfer & s_tdata[0];

    psc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psc_timing #(.LINES_PER_FRAME(LINES_PER_FRAME)) u_timing
    (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .cfg   (cfg),
        .st    (st)
    );

    psc_levels #(.LINES_PER_FRAME(LINES_PER_FRAME)) u_levels
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_xfer),
        .cfg      (cfg),
        .st       (st),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: tb/pal_sync_colorbar_generator_test.sv
// Self-checking testbench for pal_sync_colorbar_generator: tick stream in, level stream out,
// with a scoreboard class that predicts every result. Needs psc_pkg and the RTL only.
`timescale 1ns / 1ps

module pal_sync_colorbar_generator_test;

    localparam int FRAME_LINES = 625;
    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_LIMIT = 30;
    localparam logic [psc_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    // m_tdata layout, lowest bit last
    typedef struct packed {
        logic [6:0] pad;
        logic       image_line;
        logic [9:0] line_number;
        logic [2:0] rgb;
        logic       even_odd;
        logic       vsync_flag;
        logic       csync;
    } pal_levels_t;

    class pal_timing_scoreboard;
        logic [10:0] line_period;
        logic [9:0]  half_line;
        logic [7:0]  sync_width;
        logic [7:0]  eq_width;
        logic [9:0]  broad_width;
        logic [10:0] bar_start;
        logic [7:0]  bar_width;

        logic [10:0] pixel_count;
        logic [9:0]  line_count;
        logic        vsync_state;
        logic        parity_state;
        logic [3:0]  bar_index;
        logic [7:0]  bar_tick;

        pal_levels_t expected_levels[$];
        int          mismatches;

        function new();
            line_period  = psc_pkg::RST_LINE_PERIOD;
            half_line    = psc_pkg::RST_HALF_LINE;
            sync_width   = psc_pkg::RST_SYNC_WIDTH;
            eq_width     = psc_pkg::RST_EQ_WIDTH;
            broad_width  = psc_pkg::RST_BROAD_WIDTH;
            bar_start    = psc_pkg::RST_BAR_START;
            bar_width    = psc_pkg::RST_BAR_WIDTH;
            pixel_count  = '0;
            line_count   = psc_pkg::RST_LINE_COUNT;
            vsync_state  = 1'b1;
            parity_state = 1'b1;
            bar_index    = '0;
            bar_tick     = '0;
            mismatches   = 0;
        endfunction

        // pulse kind for the first half of the line after line l
        function psc_pkg::kind_t kind_after(int l);
            if (l < 2)   return psc_pkg::KIND_BROAD;
            if (l < 4)   return psc_pkg::KIND_EQ;
            if (l < 22)  return psc_pkg::KIND_SYNC;
            if (l < 309) return psc_pkg::KIND_IMAGE;
            if (l < 312) return psc_pkg::KIND_EQ;
            if (l < 314) return psc_pkg::KIND_BROAD;
            if (l < 317) return psc_pkg::KIND_EQ;
            if (l < 334) return psc_pkg::KIND_SYNC;
            if (l < 622) return psc_pkg::KIND_IMAGE;
            if (l < 624) return psc_pkg::KIND_EQ;
            return psc_pkg::KIND_BROAD;
        endfunction

        function psc_pkg::kind_t late_kind(int l);
            if (l < 2)   return psc_pkg::KIND_BROAD;
            if (l < 5)   return psc_pkg::KIND_EQ;
            if (l < 310) return psc_pkg::KIND_NONE;
            if (l < 312) return psc_pkg::KIND_EQ;
            if (l < 315) return psc_pkg::KIND_BROAD;
            if (l < 317) return psc_pkg::KIND_EQ;
            if (l < 622) return psc_pkg::KIND_NONE;
            return psc_pkg::KIND_EQ;
        endfunction

        function psc_pkg::kind_t line_kind(int l);
            return kind_after((l == 0) ? FRAME_LINES - 1 : l - 1);
        endfunction

        function int pulse_width(psc_pkg::kind_t k);
            case (k)
                psc_pkg::KIND_EQ:    return eq_width;
                psc_pkg::KIND_BROAD: return broad_width;
                psc_pkg::KIND_NONE:  return 0;
                default:             return sync_width;
            endcase
        endfunction

        // white, yellow, cyan, green, magenta, red, blue, black for bars 1..8
        function logic [2:0] bar_rgb(int b);
            case (b)
                1:       return 3'h7;
                2:       return 3'h6;
                3:       return 3'h3;
                4:       return 3'h2;
                5:       return 3'h5;
                6:       return 3'h4;
                7:       return 3'h1;
                default: return 3'h0;
            endcase
        endfunction

        function void load_register(logic [psc_pkg::CFG_ADDR_W-1:0] addr,
                                    logic [psc_pkg::CFG_DATA_W-1:0] data);
            case (addr)
                psc_pkg::REG_LINE_PERIOD: line_period = data[10:0];
                psc_pkg::REG_HALF_LINE:   half_line   = data[9:0];
                psc_pkg::REG_SYNC_WIDTH:  sync_width  = data[7:0];
                psc_pkg::REG_EQ_WIDTH:    eq_width    = data[7:0];
                psc_pkg::REG_BROAD_WIDTH: broad_width = data[9:0];
                psc_pkg::REG_BAR_START:   bar_start   = data[10:0];
                psc_pkg::REG_BAR_WIDTH:   bar_width   = data[7:0];
                default: ;
            endcase
        endfunction

        // field flags change by the rule of the line being left
        function void close_line(int l);
            if ((l >= 2 && l <= 3) || l == 314)
                vsync_state = 1'b1;
            if (l == 311)
            begin
                vsync_state  = 1'b0;
                parity_state = 1'b0;
            end
            if (l >= 624)
            begin
                vsync_state  = 1'b0;
                parity_state = 1'b1;
            end
        endfunction

        function void note_tick(bit advance);
            pal_levels_t lv;
            int          p;
            int          q;
            bit          image;
            bit          low;

            p     = pixel_count;
            image = (line_kind(line_count) == psc_pkg::KIND_IMAGE);
            if (p < half_line)
                low = (p < pulse_width(line_kind(line_count)));
            else
                low = ((p - half_line) < pulse_width(late_kind(line_count)));

            lv             = '0;
            lv.csync       = !low;
            lv.vsync_flag  = vsync_state;
            lv.even_odd    = parity_state;
            lv.rgb         = (image && bar_index >= 1 && bar_index <= 8) ? bar_rgb(bar_index) : 3'h0;
            lv.line_number = line_count;
            lv.image_line  = image;
            expected_levels.push_back(lv);

            if (!advance)
                return;
            q = p + 1;
            if (q >= line_period)
            begin
                q = 0;
                close_line(line_count);
                if (int'(line_count) + 1 >= FRAME_LINES)
                    line_count = '0;
                else
                    line_count = line_count + 10'd1;
                bar_index = '0;
                bar_tick  = '0;
            end
            pixel_count = q[10:0];
            image = (line_kind(line_count) == psc_pkg::KIND_IMAGE);
            if (!image || pixel_count < bar_start)
            begin
                bar_index = '0;
                bar_tick  = '0;
            end
            else if (pixel_count == bar_start)
            begin
                bar_index = 4'd1;
                bar_tick  = '0;
            end
            else if (bar_index >= 1 && bar_index <= 8)
            begin
                bar_tick = bar_tick + 8'd1;
                if (bar_tick >= bar_width)
                begin
                    bar_tick  = '0;
                    bar_index = bar_index + 4'd1;
                end
            end
        endfunction

        task report_mismatch(string what, int got, int want);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        endtask

        task check_levels(logic [psc_pkg::OUT_DATA_W-1:0] raw);
            pal_levels_t got;
            pal_levels_t want;

            got = raw;
            if (expected_levels.size() == 0)
            begin
                report_mismatch("result with nothing pending, data", raw, 0);
                return;
            end
            want = expected_levels.pop_front();
            if (got.csync != want.csync)
                report_mismatch("csync", got.csync, want.csync);
            if (got.vsync_flag != want.vsync_flag)
                report_mismatch("vsync_flag", got.vsync_flag, want.vsync_flag);
            if (got.even_odd != want.even_odd)
                report_mismatch("even_odd", got.even_odd, want.even_odd);
            if (got.rgb != want.rgb)
                report_mismatch("rgb", got.rgb, want.rgb);
            if (got.line_number != want.line_number)
                report_mismatch("line_number", got.line_number, want.line_number);
            if (got.image_line != want.image_line)
                report_mismatch("image_line", got.image_line, want.image_line);
            if (got.pad != want.pad)
                report_mismatch("padding", got.pad, want.pad);
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = '0;      // [0] tick
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [psc_pkg::OUT_DATA_W-1:0] m_tdata;   // csync, vsync_flag, even_odd, rgb, line, image
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [psc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [psc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    bit                             calm = 1'b1;
    int                             idle_cycles = 0;
    pal_timing_scoreboard           sb = new();

    always #1 clk = ~clk;

    pal_sync_colorbar_generator #(
        .LINES_PER_FRAME (FRAME_LINES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always @(negedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 6);

    // transfer monitor and watchdog; results are checked before the same-edge input is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_levels(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_tick(s_tdata[0]);
            if (cfg_valid && cfg_ready)
                sb.load_register(cfg_addr, cfg_data);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // random bits above the register width; the block keeps only the low bits
    function automatic logic [psc_pkg::CFG_DATA_W-1:0] with_junk(int value, int width);
        logic [31:0] v;
        v = value | ($urandom << width);
        return v[psc_pkg::CFG_DATA_W-1:0];
    endfunction

    task automatic write_reg(input logic [psc_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [psc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [10:0] period, input logic [10:0] half,
                                  input logic [10:0] sync, input logic [10:0] eq,
                                  input logic [10:0] broad, input logic [10:0] bstart,
                                  input logic [10:0] bwidth);
        write_reg(psc_pkg::REG_LINE_PERIOD, period);
        write_reg(psc_pkg::REG_HALF_LINE, half);
        write_reg(psc_pkg::REG_SYNC_WIDTH, sync);
        write_reg(psc_pkg::REG_EQ_WIDTH, eq);
        write_reg(psc_pkg::REG_BROAD_WIDTH, broad);
        write_reg(psc_pkg::REG_BAR_START, bstart);
        write_reg(psc_pkg::REG_BAR_WIDTH, bwidth);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_tick(input bit advance);
        while (!calm && $urandom_range(99) < 6)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, advance};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold_pct: share of items with tick low
    task automatic run_phase(input int count, input int hold_pct);
        for (int i = 0; i < count; i++)
            send_tick($urandom_range(99) >= hold_pct);
        s_tvalid <= 1'b0;
        while (sb.expected_levels.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [11:0] pattern;
        int          lp;
        int          hl;
        int          n;
        int          random_items;
        int          phase_count;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset values, holds mixed in, then the smallest settings with zero widths
        calm = 1'b1;
        pattern = 12'b1011_0011_0101;
        for (int i = 0; i < 12; i++)
            send_tick(pattern[i]);
        s_tvalid <= 1'b0;
        while (sb.expected_levels.size() != 0)
            @(negedge clk);
        write_reg(REG_UNUSED, 11'h7FF);
        apply_settings(11'd64, 11'd32, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0);
        pattern = 12'b1110_1101_1111;
        for (int i = 0; i < 13; i++)
            send_tick((i == 12) ? 1'b0 : pattern[i]);
        s_tvalid <= 1'b0;
        while (sb.expected_levels.size() != 0)
            @(negedge clk);

        // largest values everywhere
        calm = 1'b0;
        apply_settings(11'd2047, 11'd1023, 11'd255, 11'd255, 11'd1023, 11'd2047, 11'd255);
        run_phase(400, 3);
        random_items = 400;

        // half line past the line end, pulses longer than a half, one-tick bars
        apply_settings(11'd64, 11'd1023, 11'd255, 11'd255, 11'd1023, 11'd3, 11'd0);
        run_phase(400, 3);
        random_items += 400;

        // random settings with short lines
        phase_count = 0;
        while (random_items < 1250 && phase_count < 400)
        begin
            lp = ($urandom_range(9) == 0) ? $urandom_range(2047, 64) : $urandom_range(120, 64);
            hl = ($urandom_range(7) == 0) ? $urandom_range(1023, 32)
                                          : $urandom_range((lp > 1023) ? 1023 : lp, 32);
            apply_settings(lp[10:0],
                           with_junk(hl, 10),
                           with_junk(($urandom_range(3) == 0) ? $urandom_range(255)
                                                              : $urandom_range(24), 8),
                           with_junk(($urandom_range(3) == 0) ? $urandom_range(255)
                                                              : $urandom_range(24), 8),
                           with_junk(($urandom_range(3) == 0) ? $urandom_range(1023)
                                                              : $urandom_range(hl), 10),
                           11'(($urandom_range(7) == 0) ? $urandom_range(2047)
                                                        : $urandom_range(lp - 1)),
                           with_junk(($urandom_range(5) == 0) ? $urandom_range(255)
                                                              : $urandom_range(10), 8));
            calm = ($urandom_range(3) == 0);
            n = $urandom_range(200, 60);
            run_phase(n, ($urandom_range(5) == 0) ? 50 : 3);
            random_items += n;
            phase_count++;
        end

        repeat (4) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_levels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
